// File: design/summed_area_region_sum_unit_defines.svh
// Assertion helpers shared by the summed-area region sum block.
// Each helper samples on clk and is disabled while rst_n is low.
`ifndef SUMMED_AREA_REGION_SUM_UNIT_DEFINES_SVH
`define SUMMED_AREA_REGION_SUM_UNIT_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define SARS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent starting in the cycle after the antecedent.
`define SARS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sars_pkg.sv
package sars_pkg;

    localparam int VALUE_BITS     = 16;
    localparam int CORNER_BITS    = 6;
    localparam int SUM_BITS       = 28;
    localparam int RUN_BITS       = 22;
    localparam int STATUS_BITS    = 2;
    localparam int CFG_BITS       = 7;
    localparam int CFG_INDEX_BITS = 1;
    localparam int RESET_SIZE     = 64;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROWS = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLS = 1'd1;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                          opcode;
        logic signed [VALUE_BITS-1:0]  element_value;
        logic        [CORNER_BITS-1:0] top_row;
        logic        [CORNER_BITS-1:0] left_col;
        logic        [CORNER_BITS-1:0] bottom_row;
        logic        [CORNER_BITS-1:0] right_col;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_BITS-1:0]    region_sum;
        logic        [STATUS_BITS-1:0] status;
    } out_item_t;

endpackage

// File: design/summed_area_region_sum_unit.sv
// Load beat: read the entry above, then write back; it gives no result.
// Query beat: four table reads over the two read ports (at accept, in ST_Q_RD2), then a result strobe.
// Busy in ST_LOAD_WR and ST_Q_RD2 (two-port table: load read-modify-write, two read pairs per
// query); ST_Q_SUM takes a beat. The receiver cannot stall; each result strobe lasts one cycle.
// Reset (rst_n, async, active low) clears counters and flags, sizes go to RESET_SIZE; table contents
// stay undefined until loaded, with no clearing pass, and queries report not loaded.
`include "summed_area_region_sum_unit_defines.svh"

module summed_area_region_sum_unit
    import sars_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  in_item_t                  item,
    output logic                      result_valid,
    output out_item_t                 result,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROWS_RESET = (RESET_SIZE > MAX_ROWS) ? MAX_ROWS : RESET_SIZE;
    localparam int COLS_RESET = (RESET_SIZE > MAX_COLS) ? MAX_COLS : RESET_SIZE;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_Q_RD2,
        ST_Q_SUM
    } state_t;

    // Linear table address: row-major with a fixed stride of MAX_COLS.
    function automatic logic [ADDR_BITS-1:0] lin_addr(input logic [CFG_BITS-1:0] row,
                                                      input logic [CFG_BITS-1:0] col);
        int unsigned lin;
        lin = int'(row) * MAX_COLS + int'(col);
        return lin[ADDR_BITS-1:0];
    endfunction

    // Zero counts as one, anything above the maximum counts as the maximum.
    function automatic logic [CFG_BITS-1:0] clamp_size(input logic [CFG_BITS-1:0] v,
                                                      input int maxv);
        if (v == '0)
        begin
            return CFG_BITS'(1);
        end
        if (int'(v) > maxv)
        begin
            return CFG_BITS'(maxv);
        end
        return v;
    endfunction

    state_t                      state_reg, state_next;
    logic [CFG_BITS-1:0]         rows_reg, rows_next;
    logic [CFG_BITS-1:0]         cols_reg, cols_next;
    logic [CFG_BITS-1:0]         load_row_reg, load_row_next;
    logic [CFG_BITS-1:0]         load_col_reg, load_col_next;
    logic signed [RUN_BITS-1:0]  run_reg, run_next;
    logic                        loaded_reg, loaded_next;
    logic [ADDR_BITS-1:0]        wr_addr_reg, wr_addr_next;
    logic                        use_above_reg, use_above_next;
    logic [ADDR_BITS-1:0]        addr_c_reg, addr_c_next;
    logic [ADDR_BITS-1:0]        addr_d_reg, addr_d_next;
    logic                        use_b_reg, use_b_next;
    logic                        use_c_reg, use_c_next;
    logic [STATUS_BITS-1:0]      status_reg, status_next;
    logic signed [SUM_BITS-1:0]  partial_reg, partial_next;
    logic                        result_valid_reg, result_valid_next;
    out_item_t                   result_reg, result_next;

    logic                        accept;
    logic                        restart;
    logic [CFG_BITS-1:0]         eff_row, eff_col;
    logic [CFG_BITS-1:0]         row_inc, col_inc;
    logic signed [RUN_BITS-1:0]  run_base, run_sum;
    logic [CFG_BITS-1:0]         r1, c1, r2, c2;
    logic                        rect_bad;
    logic signed [SUM_BITS-1:0]  final_sum;

    logic                        mem_we;
    logic signed [SUM_BITS-1:0]  mem_wdata;
    logic                        rd_en;
    logic [ADDR_BITS-1:0]        raddr_a, raddr_b;
    logic signed [SUM_BITS-1:0]  rdata_a, rdata_b;

    // Hold off new beats during a load write-back and the second query read pair;
    // the write-back never meets a read of the same entry.
    assign busy   = (state_reg == ST_LOAD_WR) || (state_reg == ST_Q_RD2);
    assign accept = start && !busy;

    // Load addressing: restart at the origin after a complete matrix or a cursor outside the size.
    assign restart = loaded_reg || (load_row_reg >= rows_reg) || (load_col_reg >= cols_reg);
    assign eff_row = restart ? '0 : load_row_reg;
    assign eff_col = restart ? '0 : load_col_reg;
    assign row_inc = eff_row + CFG_BITS'(1);
    assign col_inc = eff_col + CFG_BITS'(1);
    assign run_base = (eff_col == '0) ? '0 : run_reg;
    assign run_sum  = run_base + RUN_BITS'(item.element_value);

    // Query corners, widened to the size register width.
    assign r1 = CFG_BITS'(item.top_row);
    assign c1 = CFG_BITS'(item.left_col);
    assign r2 = CFG_BITS'(item.bottom_row);
    assign c2 = CFG_BITS'(item.right_col);
    assign rect_bad = (r1 > r2) || (c1 > c2) || (r2 >= rows_reg) || (c2 >= cols_reg);

    // Table port usage: beat reads at accept, second query pair in ST_Q_RD2.
    always_comb
    begin
        rd_en   = accept || (state_reg == ST_Q_RD2);
        raddr_a = addr_c_reg;
        raddr_b = addr_d_reg;
        if (state_reg != ST_Q_RD2)
        begin
            if (item.opcode == OP_QUERY)
            begin
                raddr_a = lin_addr(r2, c2);
            end
            else
            begin
                raddr_a = lin_addr(eff_row - CFG_BITS'(1), eff_col);
            end
            raddr_b = lin_addr(r1 - CFG_BITS'(1), c2);
        end
    end

    assign mem_we    = (state_reg == ST_LOAD_WR);
    assign mem_wdata = (use_above_reg ? rdata_a : '0) + SUM_BITS'(run_reg);

    assign final_sum = partial_reg - (use_c_reg ? rdata_a : '0)
                     + ((use_b_reg && use_c_reg) ? rdata_b : '0);

    always_comb
    begin
        state_next        = state_reg;
        rows_next         = rows_reg;
        cols_next         = cols_reg;
        load_row_next     = load_row_reg;
        load_col_next     = load_col_reg;
        run_next          = run_reg;
        loaded_next       = loaded_reg;
        wr_addr_next      = wr_addr_reg;
        use_above_next    = use_above_reg;
        addr_c_next       = addr_c_reg;
        addr_d_next       = addr_d_reg;
        use_b_next        = use_b_reg;
        use_c_next        = use_c_reg;
        status_next       = status_reg;
        partial_next      = partial_reg;
        result_valid_next = (state_reg == ST_Q_SUM);
        result_next       = result_reg;

        case (state_reg)
            ST_IDLE, ST_Q_SUM:
            begin
                if (accept)
                begin
                    state_next = (item.opcode == OP_QUERY) ? ST_Q_RD2 : ST_LOAD_WR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_Q_RD2:
            begin
                state_next = ST_Q_SUM;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Combine the first read pair while the second pair is in flight.
        if (state_reg == ST_Q_RD2)
        begin
            partial_next = rdata_a - (use_b_reg ? rdata_b : '0);
        end

        // Drop the sum on any error status.
        if (state_reg == ST_Q_SUM)
        begin
            result_next.status     = status_reg;
            result_next.region_sum = (status_reg == STATUS_OK) ? final_sum : '0;
        end

        if (accept)
        begin
            if (item.opcode == OP_LOAD)
            begin
                run_next       = run_sum;
                wr_addr_next   = lin_addr(eff_row, eff_col);
                use_above_next = (eff_row != '0);
                loaded_next    = 1'b0;
                load_row_next  = eff_row;
                load_col_next  = col_inc;
                if (col_inc >= cols_reg)
                begin
                    load_col_next = '0;
                    load_row_next = row_inc;
                    if (row_inc >= rows_reg)
                    begin
                        load_row_next = '0;
                        loaded_next   = 1'b1;
                    end
                end
            end
            else
            begin
                use_b_next  = (r1 != '0);
                use_c_next  = (c1 != '0);
                addr_c_next = lin_addr(r2, c1 - CFG_BITS'(1));
                addr_d_next = lin_addr(r1 - CFG_BITS'(1), c1 - CFG_BITS'(1));
                if (!loaded_reg)
                begin
                    status_next = STATUS_EMPTY;
                end
                else if (rect_bad)
                begin
                    status_next = STATUS_RANGE;
                end
                else
                begin
                    status_next = STATUS_OK;
                end
            end
        end

        // A size write restarts loading; the table itself is left alone.
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS:
                begin
                    rows_next = clamp_size(cfg_data, MAX_ROWS);
                end
                CFG_COLS:
                begin
                    cols_next = clamp_size(cfg_data, MAX_COLS);
                end
                default:
                begin
                    rows_next = rows_reg;
                end
            endcase
            load_row_next = '0;
            load_col_next = '0;
            run_next      = '0;
            loaded_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rows_reg         <= CFG_BITS'(ROWS_RESET);
            cols_reg         <= CFG_BITS'(COLS_RESET);
            load_row_reg     <= '0;
            load_col_reg     <= '0;
            run_reg          <= '0;
            loaded_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rows_reg         <= rows_next;
            cols_reg         <= cols_next;
            load_row_reg     <= load_row_next;
            load_col_reg     <= load_col_next;
            run_reg          <= run_next;
            loaded_reg       <= loaded_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        wr_addr_reg   <= wr_addr_next;
        use_above_reg <= use_above_next;
        addr_c_reg    <= addr_c_next;
        addr_d_reg    <= addr_d_next;
        use_b_reg     <= use_b_next;
        use_c_reg     <= use_c_next;
        status_reg    <= status_next;
        partial_reg   <= partial_next;
        result_reg    <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    sars_table #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS)
    ) u_table (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (wr_addr_reg),
        .wdata   (mem_wdata),
        .rd_en   (rd_en),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    `SARS_ASSERT_SAME(a_wb_no_accept, mem_we, !accept,
        "load write-back overlapped an accepted beat")
    `SARS_ASSERT_NEXT(a_query_result, accept && (item.opcode == OP_QUERY),
        ##2 result_valid, "query beat did not produce a result strobe")
    `SARS_ASSERT_SAME(a_strobe_source, result_valid, $past(state_reg == ST_Q_SUM),
        "result strobe without a finished query")
    `SARS_ASSERT_SAME(a_loaded_rise, $rose(loaded_reg), state_reg == ST_LOAD_WR,
        "table marked loaded outside a load beat")

endmodule

// File: design/sars_table.sv
// Summed-area table storage: one write port, two registered read ports.
module sars_table
    import sars_pkg::*;
#(
    parameter int DEPTH     = 4096,
    parameter int ADDR_BITS = 12
)
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_BITS-1:0]       waddr,
    input  logic signed [SUM_BITS-1:0] wdata,
    input  logic                       rd_en,
    input  logic [ADDR_BITS-1:0]       raddr_a,
    input  logic [ADDR_BITS-1:0]       raddr_b,
    output logic signed [SUM_BITS-1:0] rdata_a,
    output logic signed [SUM_BITS-1:0] rdata_b
);

    logic signed [SUM_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// File: tb/tb_summed_area_region_sum_unit.sv
`timescale 1ns / 100ps

module tb_summed_area_region_sum_unit;
    import sars_pkg::*;

    // Table geometry of the block as built (default parameters).
    localparam int MAX_DIM       = 64;
    localparam int RANDOM_ITEMS  = 800;
    // Sizes whose product exceeds this get a narrow second dimension, to keep fills short.
    localparam int FILL_CAP      = 128;
    // Margin for a query strobe or a load write-back still in flight.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 200;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic { STEP_BEAT, STEP_SIZE } step_kind_t;

    typedef struct {
        step_kind_t                kind;
        logic [CFG_INDEX_BITS-1:0] reg_idx;
        logic [CFG_BITS-1:0]       reg_val;
        in_item_t                  beat;
        bit                        typed;
        out_item_t                 typed_out;
    } plan_row_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      start     = 1'b0;
    logic                      busy;
    in_item_t                  item      = '0;
    logic                      result_valid;
    out_item_t                 result;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]       cfg_data  = '0;

    // Mirror of the block: table, row accumulator, fill cursor, sizes.
    logic signed [SUM_BITS-1:0] mirror_table [MAX_DIM*MAX_DIM];
    logic signed [RUN_BITS-1:0] mirror_run;
    int                         mirror_row;
    int                         mirror_col;
    bit                         mirror_loaded;
    int                         mirror_rows;
    int                         mirror_cols;

    // Sums the block still owes, oldest first.
    out_item_t sums_due [$];

    int  fail_count   = 0;
    int  beats_issued = 0;
    int  cycle_count  = 0;
    bit  no_idle      = 1'b0;

    summed_area_region_sum_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: a hung handshake or a lost strobe ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("summed_area_region_sum_unit regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Mirror of the block
    // ---------------------------------------------------------------

    function automatic int clamp_size(input int v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    // Rewind the fill cursor to row 0, column 0 and drop the loaded flag.
    task automatic restart_fill();
        mirror_run    = '0;
        mirror_row    = 0;
        mirror_col    = 0;
        mirror_loaded = 1'b0;
    endtask

    task automatic apply_size_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [CFG_BITS-1:0] val);
        if (idx == CFG_ROWS)
            mirror_rows = clamp_size(int'(val));
        else
            mirror_cols = clamp_size(int'(val));
        restart_fill();
    endtask

    // Advance the mirror by one accepted beat; a query yields the sum it owes.
    task automatic apply_beat(input in_item_t it, output bit gives, output out_item_t res);
        logic signed [SUM_BITS-1:0] above;
        logic signed [SUM_BITS-1:0] acc;
        int r1;
        int c1;
        int r2;
        int c2;
        gives = 1'b0;
        res   = '0;
        if (it.opcode == OP_LOAD)
        begin
            // A load after a complete table begins a new matrix.
            if (mirror_loaded)
                restart_fill();
            if (mirror_row >= mirror_rows || mirror_col >= mirror_cols)
                restart_fill();
            if (mirror_col == 0)
                mirror_run = '0;
            mirror_run = mirror_run + signed'(it.element_value);
            above = '0;
            if (mirror_row > 0)
                above = mirror_table[(mirror_row - 1) * MAX_DIM + mirror_col];
            mirror_table[mirror_row * MAX_DIM + mirror_col] = above + mirror_run;
            mirror_col++;
            if (mirror_col >= mirror_cols)
            begin
                mirror_col = 0;
                mirror_row++;
                if (mirror_row >= mirror_rows)
                begin
                    mirror_row    = 0;
                    mirror_loaded = 1'b1;
                end
            end
        end
        else
        begin
            gives = 1'b1;
            r1 = int'(it.top_row);
            c1 = int'(it.left_col);
            r2 = int'(it.bottom_row);
            c2 = int'(it.right_col);
            // The not-loaded check wins over the rectangle check.
            if (!mirror_loaded)
                res.status = STATUS_EMPTY;
            else if (r1 > r2 || c1 > c2 || r2 >= mirror_rows || c2 >= mirror_cols)
                res.status = STATUS_RANGE;
            else
            begin
                acc = mirror_table[r2 * MAX_DIM + c2];
                if (r1 > 0)
                    acc = acc - mirror_table[(r1 - 1) * MAX_DIM + c2];
                if (c1 > 0)
                    acc = acc - mirror_table[r2 * MAX_DIM + (c1 - 1)];
                if (r1 > 0 && c1 > 0)
                    acc = acc + mirror_table[(r1 - 1) * MAX_DIM + (c1 - 1)];
                res.region_sum = acc;
                res.status     = STATUS_OK;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Result check: every strobe must match the oldest owed sum
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && result_valid)
        begin
            if (sums_due.size() == 0)
            begin
                $error("result strobe with nothing owed: region_sum %0d status %0d",
                       result.region_sum, result.status);
                fail_count++;
            end
            else
            begin
                want = sums_due.pop_front();
                if (result.region_sum !== want.region_sum)
                begin
                    $error("region_sum mismatch: expected %0d, actual %0d",
                           want.region_sum, result.region_sum);
                    fail_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, result.status);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Size register codes: both out-of-range ends, the limits, and mostly small sizes.
    function automatic int pick_size_code();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 127;
            2:       return MAX_DIM;
            3:       return $urandom_range(MAX_DIM + 1, 126);
            4:       return 1;
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.opcode        = 1'($urandom_range(0, 1));
        it.element_value = VALUE_BITS'($urandom());
        it.top_row       = CORNER_BITS'($urandom());
        it.left_col      = CORNER_BITS'($urandom());
        it.bottom_row    = CORNER_BITS'($urandom());
        it.right_col     = CORNER_BITS'($urandom());
        return it;
    endfunction

    // Load beat with random corners (ignored) and an element that is often an extreme.
    function automatic in_item_t make_load();
        in_item_t it;
        it        = random_item();
        it.opcode = OP_LOAD;
        case ($urandom_range(0, 7))
            0:       it.element_value = 16'sh7FFF;
            1:       it.element_value = 16'sh8000;
            default: ;
        endcase
        return it;
    endfunction

    // Well-formed queries stay inside the current size; the rest keep raw corners.
    function automatic in_item_t make_query(input bit well_formed);
        in_item_t it;
        it        = random_item();
        it.opcode = OP_QUERY;
        if (well_formed)
        begin
            it.top_row    = CORNER_BITS'($urandom_range(0, mirror_rows - 1));
            it.bottom_row = CORNER_BITS'($urandom_range(int'(it.top_row), mirror_rows - 1));
            it.left_col   = CORNER_BITS'($urandom_range(0, mirror_cols - 1));
            it.right_col  = CORNER_BITS'($urandom_range(int'(it.left_col), mirror_cols - 1));
        end
        return it;
    endfunction

    function automatic plan_row_t plan_load(input logic signed [VALUE_BITS-1:0] v,
                                            input logic [CORNER_BITS-1:0] corner);
        plan_row_t row;
        row                    = '{kind: STEP_BEAT, default: '0};
        row.kind               = STEP_BEAT;
        row.beat.opcode        = OP_LOAD;
        row.beat.element_value = v;
        row.beat.top_row       = corner;
        row.beat.left_col      = corner;
        row.beat.bottom_row    = corner;
        row.beat.right_col     = corner;
        return row;
    endfunction

    // Typed rows are error cases: sum zero and the given status.
    function automatic plan_row_t plan_query(input int r1, input int c1, input int r2,
                                             input int c2, input logic [VALUE_BITS-1:0] v,
                                             input bit typed,
                                             input logic [STATUS_BITS-1:0] st);
        plan_row_t row;
        row                    = '{kind: STEP_BEAT, default: '0};
        row.kind               = STEP_BEAT;
        row.beat.opcode        = OP_QUERY;
        row.beat.element_value = v;
        row.beat.top_row       = CORNER_BITS'(r1);
        row.beat.left_col      = CORNER_BITS'(c1);
        row.beat.bottom_row    = CORNER_BITS'(r2);
        row.beat.right_col     = CORNER_BITS'(c2);
        row.typed              = typed;
        row.typed_out.status   = st;
        return row;
    endfunction

    function automatic plan_row_t plan_size(input logic [CFG_INDEX_BITS-1:0] idx,
                                            input logic [CFG_BITS-1:0] val);
        plan_row_t row;
        row         = '{kind: STEP_SIZE, default: '0};
        row.kind    = STEP_SIZE;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // Offer one beat, hold it until the block takes it, then record what it owes.
    task automatic send_beat(input in_item_t it, input bit typed, input out_item_t typed_out);
        bit        gives;
        out_item_t res;
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_beat(it, gives, res);
        if (gives)
        begin
            if (typed)
                res = typed_out;
            sums_due.push_back(res);
        end
        beats_issued++;
    endtask

    // Drop start for the requested cycles and put noise on the item bus meanwhile.
    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            item  <= random_item();
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Wait out every owed result, then let any load still in flight finish.
    task automatic drain_results();
        int waited;
        waited = 0;
        while (sums_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_INDEX_BITS-1:0] idx,
                              input logic [CFG_BITS-1:0] val);
        start <= 1'b0;
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_size_write(idx, val);
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial
    begin : stimulus
        plan_row_t plan [$];
        out_item_t none;
        int        rows_code;
        int        cols_code;
        int        fill_len;
        int        part;

        none = '0;
        for (int i = 0; i < MAX_DIM * MAX_DIM; i++)
            mirror_table[i] = '0;
        mirror_rows = RESET_SIZE;
        mirror_cols = RESET_SIZE;
        restart_fill();

        // Directed part: reset state, a 2x2 matrix of extremes, every error path,
        // a refill that starts a new matrix, and out-of-range size codes.
        plan.push_back(plan_query(0, 0, 0, 0, 16'h0000, 1'b1, STATUS_EMPTY));
        plan.push_back(plan_size(CFG_ROWS, 7'd2));
        plan.push_back(plan_size(CFG_COLS, 7'd2));
        plan.push_back(plan_load(16'sh7FFF, 6'd63));
        plan.push_back(plan_query(0, 0, 0, 0, 16'hFFFF, 1'b1, STATUS_EMPTY));
        plan.push_back(plan_load(16'sh8000, 6'd0));
        plan.push_back(plan_load(16'sd1, 6'd21));
        plan.push_back(plan_load(-16'sd1, 6'd42));
        plan.push_back(plan_query(0, 0, 1, 1, 16'h0000, 1'b0, STATUS_OK));
        plan.push_back(plan_query(1, 1, 1, 1, 16'hFFFF, 1'b0, STATUS_OK));
        plan.push_back(plan_query(0, 1, 1, 1, 16'h5A5A, 1'b0, STATUS_OK));
        plan.push_back(plan_query(1, 0, 0, 1, 16'h0000, 1'b1, STATUS_RANGE));
        plan.push_back(plan_query(0, 1, 1, 0, 16'h0000, 1'b1, STATUS_RANGE));
        plan.push_back(plan_query(0, 0, 2, 1, 16'h0000, 1'b1, STATUS_RANGE));
        plan.push_back(plan_query(0, 0, 1, 2, 16'h0000, 1'b1, STATUS_RANGE));
        plan.push_back(plan_query(63, 63, 63, 63, 16'hFFFF, 1'b1, STATUS_RANGE));
        plan.push_back(plan_load(16'sd5, 6'd63));
        plan.push_back(plan_query(0, 0, 0, 0, 16'h0000, 1'b1, STATUS_EMPTY));
        plan.push_back(plan_load(16'sd7, 6'd0));
        plan.push_back(plan_load(-16'sd9, 6'd0));
        plan.push_back(plan_load(16'sd11, 6'd0));
        plan.push_back(plan_query(0, 0, 1, 1, 16'h8000, 1'b0, STATUS_OK));
        plan.push_back(plan_size(CFG_ROWS, 7'd0));
        plan.push_back(plan_size(CFG_COLS, 7'd127));
        plan.push_back(plan_query(0, 0, 0, 0, 16'h0000, 1'b1, STATUS_EMPTY));

        // Hold reset at start, then release it once.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_SIZE)
                write_size(plan[i].reg_idx, plan[i].reg_val);
            else
            begin
                send_beat(plan[i].beat, plan[i].typed, plan[i].typed_out);
                pause(pick_gap());
            end
        end

        // Random phases: new sizes, one or two full fills with stray early queries,
        // a burst of queries per fill, and sometimes a fill left unfinished.
        beats_issued = 0;
        while (beats_issued < RANDOM_ITEMS)
        begin
            no_idle   = ($urandom_range(0, 4) == 0);
            rows_code = pick_size_code();
            cols_code = pick_size_code();
            if (clamp_size(rows_code) * clamp_size(cols_code) > FILL_CAP)
                cols_code = $urandom_range(0, 2);
            if ($urandom_range(0, 1) == 1)
            begin
                write_size(CFG_ROWS, CFG_BITS'(rows_code));
                write_size(CFG_COLS, CFG_BITS'(cols_code));
            end
            else
            begin
                write_size(CFG_COLS, CFG_BITS'(cols_code));
                write_size(CFG_ROWS, CFG_BITS'(rows_code));
            end

            fill_len = mirror_rows * mirror_cols;
            repeat ($urandom_range(1, 2))
            begin
                for (int k = 0; k < fill_len; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_beat(make_query($urandom_range(0, 1) == 1), 1'b0, none);
                        pause(pick_gap());
                    end
                    send_beat(make_load(), 1'b0, none);
                    pause(pick_gap());
                end
                repeat ($urandom_range(4, 12))
                begin
                    send_beat(make_query($urandom_range(0, 4) != 0), 1'b0, none);
                    pause(pick_gap());
                end
            end

            if (fill_len > 1 && $urandom_range(0, 3) == 0)
            begin
                part = $urandom_range(1, fill_len - 1);
                repeat (part)
                begin
                    send_beat(make_load(), 1'b0, none);
                    pause(pick_gap());
                end
                repeat (2)
                begin
                    send_beat(make_query(1'b1), 1'b0, none);
                    pause(pick_gap());
                end
            end
        end

        // Idle the input, collect the last results, then report.
        start <= 1'b0;
        drain_results();
        if (sums_due.size() != 0)
        begin
            $error("%0d owed results never arrived", sums_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("summed_area_region_sum_unit regression: pass");
        else
            $display("summed_area_region_sum_unit regression: fail");
        $finish;
    end

endmodule
